// ===== src/pbmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbmpd_pkg: shared definitions for the backward marked-place distance search
// Field widths, request command codes, configuration register indexes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pbmpd_pkg;

  // Fixed field widths
  localparam int ROW_W     = 64;  // place bitmap / arc row width
  localparam int IDX_W     = 6;   // transition index and start place width
  localparam int CNT_W     = 7;   // place / transition count registers
  localparam int DIST_W    = 7;   // result distance width
  localparam int CMD_W     = 2;   // request command width
  localparam int CFG_IDX_W = 1;   // configuration register index width

  // Request command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_ARCS = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_MARK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLACE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_COUNT = 1'b1;

  // Count register value after reset
  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

  // Controller to datapath
  typedef struct packed {
    logic load_arcs;    // write one transition's arc rows
    logic load_mark;    // write marking bitmap
    logic start_query;  // seed frontier with start place
    logic scan_rd;      // read arc rows at scan counter, advance it
    logic next_level;   // promote gathered places to next frontier
    logic load_result;  // capture distance into output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic found;      // marked place reached at current level
    logic acc_empty;  // no new place gathered at current level
    logic scan_last;  // scan counter at last transition in use
    logic nt_zero;    // no transition in use
  } ctrl_sts_t;

endpackage

// ===== src/pbmpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbmpd_ctrl: sequencer for loads and level-by-level backward search
// Decodes requests, walks the transition scan of each level, decides at the
// end of each level whether to finish, and owns the output valid flag.
// ----------------------------------------------------------------------------
module pbmpd_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [pbmpd_pkg::CMD_W-1:0]    in_command,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pbmpd_pkg::ctrl_cmd_t           cmd,
  input  pbmpd_pkg::ctrl_sts_t           sts
);
  import pbmpd_pkg::*;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SCAN      = 3'd1;
  localparam logic [2:0] ST_DRAIN     = 3'd2;
  localparam logic [2:0] ST_LEVEL_END = 3'd3;
  localparam logic [2:0] ST_RESULT    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_command)
            CMD_LOAD_ARCS: cmd.load_arcs = 1'b1;
            CMD_LOAD_MARK: cmd.load_mark = 1'b1;
            CMD_QUERY: begin
              cmd.start_query = 1'b1;
              state_nxt = sts.nt_zero ? ST_LEVEL_END : ST_SCAN;
            end
            default: ;  // unused code: dropped
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_LEVEL_END;
      ST_LEVEL_END: begin
        if (sts.found || sts.acc_empty) begin
          state_nxt = ST_RESULT;
        end else begin
          cmd.next_level = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_result = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on capture, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_result)   out_valid_nxt = 1'b1;
    else if (out_ready)    out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |-> (!out_valid_r || out_ready))
    else $error("result captured over a pending result");

  // An accepted query always leaves idle
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_command == CMD_QUERY)
      |=> (state_r == ST_SCAN || state_r == ST_LEVEL_END))
    else $error("query accepted but search not started");

  // Last read of a level is always drained before the level decision
  a_drain_then_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> (state_r == ST_LEVEL_END))
    else $error("level decision skipped after drain");

endmodule

// ===== src/pbmpd_datapath.sv =====
// ----------------------------------------------------------------------------
// pbmpd_datapath: arc row memories, frontier bitmaps and result register
// Holds the configuration registers, the producer/consumer row memories, the
// marking bitmap and the per-level frontier, visited and gathered bitmaps.
// ----------------------------------------------------------------------------
module pbmpd_datapath #(
  parameter int MAX_PLACES      = 64,
  parameter int MAX_TRANSITIONS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [pbmpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pbmpd_pkg::CNT_W-1:0]       cfg_data,
  input  logic [pbmpd_pkg::IDX_W-1:0]       in_transition_index,
  input  logic [pbmpd_pkg::ROW_W-1:0]       in_output_place_row,
  input  logic [pbmpd_pkg::ROW_W-1:0]       in_input_place_row,
  input  logic [pbmpd_pkg::ROW_W-1:0]       in_marked_bitmap,
  input  logic [pbmpd_pkg::IDX_W-1:0]       in_start_place,
  output logic [pbmpd_pkg::DIST_W-1:0]      out_arc_distance,
  input  pbmpd_pkg::ctrl_cmd_t              cmd,
  output pbmpd_pkg::ctrl_sts_t              sts
);
  import pbmpd_pkg::*;

  localparam int TA_W = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int TC_W = $clog2(MAX_TRANSITIONS + 1);
  localparam int CW   = (TC_W > CNT_W) ? TC_W : CNT_W;
  localparam int LV_W = $clog2(MAX_PLACES + 2);

  logic [CNT_W-1:0]  place_count_r, trans_count_r;
  logic [CNT_W-1:0]  np;
  logic [CW-1:0]     tc_ext;
  logic [TC_W-1:0]   nt;
  logic [ROW_W-1:0]  place_mask;

  logic [ROW_W-1:0]  prod_mem [MAX_TRANSITIONS];
  logic [ROW_W-1:0]  cons_mem [MAX_TRANSITIONS];
  logic [ROW_W-1:0]  prod_q_r, cons_q_r;
  logic              wr_ok;
  logic [TA_W-1:0]   wr_addr, rd_addr;

  logic [TC_W-1:0]   t_cnt_r;
  logic              rd_vld_r;
  logic [ROW_W-1:0]  marked_r;
  logic [ROW_W-1:0]  frontier_r, visited_r, acc_r;
  logic              found_r;
  logic [LV_W-1:0]   level_r;
  logic [DIST_W-1:0] dist_r;
  logic              hit;
  logic [ROW_W-1:0]  fresh;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      place_count_r <= COUNT_RESET;
      trans_count_r <= COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PLACE_COUNT: place_count_r <= cfg_data;
        CFG_TRANS_COUNT: trans_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Counts saturate at the configured maxima
  assign np = (place_count_r > CNT_W'(MAX_PLACES)) ? CNT_W'(MAX_PLACES) : place_count_r;
  assign tc_ext = CW'(trans_count_r);
  assign nt = (tc_ext > CW'(MAX_TRANSITIONS)) ? TC_W'(MAX_TRANSITIONS) : TC_W'(tc_ext);

  // Places in use
  for (genvar p = 0; p < ROW_W; p++) begin : g_mask
    assign place_mask[p] = (CNT_W'(p) < np);
  end

  // Arc row memories: one write port, one registered read port
  assign wr_ok   = (32'(in_transition_index) < 32'(MAX_TRANSITIONS));
  assign wr_addr = TA_W'(in_transition_index);
  assign rd_addr = t_cnt_r[TA_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_arcs && wr_ok) begin
      prod_mem[wr_addr] <= in_output_place_row;
      cons_mem[wr_addr] <= in_input_place_row;
    end
    prod_q_r <= prod_mem[rd_addr];
    cons_q_r <= cons_mem[rd_addr];
  end

  // Scan counter and read-data valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_cnt_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.start_query || cmd.next_level) t_cnt_r <= '0;
      else if (cmd.scan_rd)                  t_cnt_r <= t_cnt_r + TC_W'(1);
    end
  end

  // Marking bitmap
  always_ff @(posedge clk) begin
    if (!rst_n)             marked_r <= '0;
    else if (cmd.load_mark) marked_r <= in_marked_bitmap;
  end

  // Transition feeds the frontier: its unvisited inputs join the next level
  assign hit   = |(prod_q_r & frontier_r);
  assign fresh = cons_q_r & place_mask & ~visited_r;

  // Level bitmaps
  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      frontier_r <= ROW_W'(1) << in_start_place;
      visited_r  <= ROW_W'(1) << in_start_place;
      acc_r      <= '0;
      found_r    <= 1'b0;
      level_r    <= '0;
    end else if (cmd.next_level) begin
      frontier_r <= acc_r;
      visited_r  <= visited_r | acc_r;
      acc_r      <= '0;
      level_r    <= level_r + LV_W'(1);
    end else if (rd_vld_r && hit) begin
      acc_r   <= acc_r | fresh;
      found_r <= found_r | (|(fresh & marked_r));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_result) dist_r <= DIST_W'(level_r + LV_W'(1));
  end

  assign out_arc_distance = dist_r;

  assign sts.found     = found_r;
  assign sts.acc_empty = (acc_r == '0);
  assign sts.scan_last = (t_cnt_r == nt - TC_W'(1));
  assign sts.nt_zero   = (nt == '0);

  // A new level only starts when the previous one found something new but no marked place
  a_level_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.next_level |-> (!found_r && acc_r != '0))
    else $error("level advanced without new places or after a hit");

  // Read data is only consumed in the cycle after a scan read
  a_rd_follows: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(cmd.scan_rd))
    else $error("arc row consumed without a read");

  // Scan stays within the transitions in use
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> (t_cnt_r < nt))
    else $error("scan beyond transitions in use");

endmodule

// ===== src/petri_backward_marked_place_distance_top.sv =====
// Timing: loads are accepted back to back. A query walks its levels in turn; each
// level reads one arc row a cycle for the T transitions in use, then drains (no
// level reads when no transition is in use). A new request can be accepted in the
// same cycle that the result is presented.
// Reset (synchronous, active low) clears control state, the marking bitmap and
// sets both counts to 64; arc row memories are not cleared and need loading.
// ----------------------------------------------------------------------------
// petri_backward_marked_place_distance_top: backward BFS arc distance
// Loads a net's arc rows and marking, then answers queries for the backward
// arc depth from a start place to its nearest marked place.
// ----------------------------------------------------------------------------
module petri_backward_marked_place_distance_top #(
  parameter int MAX_PLACES      = 64,
  parameter int MAX_TRANSITIONS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pbmpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pbmpd_pkg::CNT_W-1:0]       cfg_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pbmpd_pkg::CMD_W-1:0]       in_command,
  input  logic [pbmpd_pkg::IDX_W-1:0]       in_transition_index,
  input  logic [pbmpd_pkg::ROW_W-1:0]       in_output_place_row,
  input  logic [pbmpd_pkg::ROW_W-1:0]       in_input_place_row,
  input  logic [pbmpd_pkg::ROW_W-1:0]       in_marked_bitmap,
  input  logic [pbmpd_pkg::IDX_W-1:0]       in_start_place,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pbmpd_pkg::DIST_W-1:0]      out_arc_distance
);
  import pbmpd_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // The user must write configuration only while idle; the block does not enforce this: always ready
  assign cfg_ready = 1'b1;

  // Sequencer
  pbmpd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Memories, bitmaps and result register
  pbmpd_datapath #(
    .MAX_PLACES      (MAX_PLACES),
    .MAX_TRANSITIONS (MAX_TRANSITIONS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_transition_index (in_transition_index),
    .in_output_place_row (in_output_place_row),
    .in_input_place_row  (in_input_place_row),
    .in_marked_bitmap    (in_marked_bitmap),
    .in_start_place      (in_start_place),
    .out_arc_distance    (out_arc_distance),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule
